>>> hw/rtl/telemetry_frame_stuffer_assert.svh
// Assertion macros shared by the telemetry frame stuffer checkers.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TELEMETRY_FRAME_STUFFER_ASSERT_SVH
`define TELEMETRY_FRAME_STUFFER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define TFS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define TFS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/tfs_pkg.sv
// Package for the telemetry frame stuffer: beat types, queue entry and
// framing constants. No dependencies.
`timescale 1ns / 1ps

package tfs_pkg;

  localparam int unsigned PayloadBytes = 7;
  localparam int unsigned IdxW         = $clog2(PayloadBytes + 1);

  localparam logic [7:0] FrameDelim  = 8'h7E;
  localparam logic [7:0] EscapeByte  = 8'h7D;
  localparam logic [7:0] SubstDelim  = 8'h5E;
  localparam logic [7:0] SubstEscape = 8'h5D;
  localparam logic [7:0] ByteMask    = 8'hFF;

  // One telemetry record as it arrives.
  typedef struct packed {
    logic [7:0]  frame_header;
    logic [15:0] sensor_data_id;
    logic [31:0] payload_value;
  } rec_t;

  // One wire byte as it leaves.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } beat_t;

  // A classified frame waiting for the serializer.
  typedef struct packed {
    logic [PayloadBytes-1:0][7:0] bytes;
    logic [PayloadBytes-1:0]      esc;
    logic [7:0]                   cksum;
  } entry_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hw/rtl/tfs_front.sv
// Front part: splits a record into payload bytes, flags bytes that need
// stuffing and computes the checksum. Depends on tfs_pkg.
`timescale 1ns / 1ps

module tfs_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tfs_pkg::rec_t      in_data_i,
  input  tfs_pkg::q_status_t q_status_i,
  output logic               push_o,
  output tfs_pkg::entry_t    entry_o
);

  logic [tfs_pkg::PayloadBytes-1:0][7:0] bytes;
  logic [tfs_pkg::PayloadBytes-1:0]      esc;
  logic [10:0] total;
  logic [8:0]  fold1;
  logic [7:0]  fold2;

  // Payload order: header, then id and value low byte first.
  assign bytes[0] = in_data_i.frame_header;
  assign bytes[1] = in_data_i.sensor_data_id[7:0];
  assign bytes[2] = in_data_i.sensor_data_id[15:8];
  assign bytes[3] = in_data_i.payload_value[7:0];
  assign bytes[4] = in_data_i.payload_value[15:8];
  assign bytes[5] = in_data_i.payload_value[23:16];
  assign bytes[6] = in_data_i.payload_value[31:24];

  // Flag bytes that collide with the delimiter or the escape byte.
  always_comb begin
    for (int i = 0; i < tfs_pkg::PayloadBytes; i++) begin
      esc[i] = (bytes[i] == tfs_pkg::FrameDelim) ||
               (bytes[i] == tfs_pkg::EscapeByte);
    end
  end

  // The end-around-carry sum equals the plain sum folded twice.
  always_comb begin
    total = '0;
    for (int i = 0; i < tfs_pkg::PayloadBytes; i++) begin
      total = total + {3'b000, bytes[i]};
    end
    fold1 = {1'b0, total[7:0]} + {6'b000000, total[10:8]};
    fold2 = fold1[7:0] + {7'b0000000, fold1[8]};
  end

  assign entry_o.bytes = bytes;
  assign entry_o.esc   = esc;
  assign entry_o.cksum = tfs_pkg::ByteMask - fold2;

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

endmodule

>>> hw/rtl/tfs_queue.sv
// Short queue of classified frames between the front and the back.
// Depends on tfs_pkg.
`timescale 1ns / 1ps

module tfs_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tfs_pkg::entry_t    entry_i,
  input  logic               pop_i,
  output tfs_pkg::entry_t    head_o,
  output tfs_pkg::q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tfs_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage holds the payload bytes, escape flags and checksum of each frame.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);

endmodule

>>> hw/rtl/tfs_back.sv
// Back part: walks the head frame one wire byte per beat, inserting
// escape pairs, and ends with the checksum. Depends on tfs_pkg.
`timescale 1ns / 1ps

module tfs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfs_pkg::entry_t    head_i,
  input  tfs_pkg::q_status_t q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tfs_pkg::beat_t     out_data_o
);

  localparam logic [tfs_pkg::IdxW-1:0] LastIdx = tfs_pkg::IdxW'(tfs_pkg::PayloadBytes);

  logic [tfs_pkg::IdxW-1:0] idx_q, idx_d;
  logic                     sub_q, sub_d;
  logic                     out_valid_q, out_valid_d;
  tfs_pkg::beat_t           out_q, out_d;
  logic                     adv;
  logic [7:0]               cur_byte;
  logic                     cur_esc;

  // The output register moves when it is empty or its beat is taken.
  assign adv = !out_valid_q || !out_stall_i;

  always_comb begin
    cur_byte = '0;
    cur_esc  = 1'b0;
    for (int i = 0; i < tfs_pkg::PayloadBytes; i++) begin
      if (idx_q == tfs_pkg::IdxW'(i)) begin
        cur_byte = head_i.bytes[i];
        cur_esc  = head_i.esc[i];
      end
    end
  end

  // Pick the next wire byte of the head frame.
  always_comb begin
    idx_d       = idx_q;
    sub_d       = sub_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (adv) begin
      out_valid_d = !q_status_i.empty;
      if (!q_status_i.empty) begin
        if (idx_q == LastIdx) begin
          out_d.out_byte  = head_i.cksum;
          out_d.frame_end = 1'b1;
          idx_d           = '0;
          pop_o           = 1'b1;
        end else if (cur_esc && !sub_q) begin
          out_d.out_byte  = tfs_pkg::EscapeByte;
          out_d.frame_end = 1'b0;
          sub_d           = 1'b1;
        end else if (cur_esc) begin
          out_d.out_byte  = (cur_byte == tfs_pkg::FrameDelim) ? tfs_pkg::SubstDelim
                                                               : tfs_pkg::SubstEscape;
          out_d.frame_end = 1'b0;
          sub_d           = 1'b0;
          idx_d           = idx_q + 1'b1;
        end else begin
          out_d.out_byte  = cur_byte;
          out_d.frame_end = 1'b0;
          idx_d           = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/telemetry_frame_stuffer.sv
// Telemetry frame stuffer: one record in, 8 to 15 stuffed wire beats out.
// The first beat of a frame passes through the queue and then the output register of the back serializer.
// The back serializer sends one beat per cycle while a frame is queued and the output is not stalled.
// The queue takes further records while a frame is still being sent.
// Reset clears queue pointers and fill count, serializer index, escape flag and
// output valid; the data registers are not reset.
`timescale 1ns / 1ps

module telemetry_frame_stuffer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tfs_pkg::rec_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tfs_pkg::beat_t out_data_o
);

  tfs_pkg::entry_t    push_entry;
  tfs_pkg::entry_t    head_entry;
  tfs_pkg::q_status_t q_status;
  logic               push;
  logic               pop;

  // Classify records and compute checksums.
  tfs_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Frames waiting to be sent.
  tfs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head_entry),
    .status_o (q_status)
  );

  // Serialize the head frame.
  tfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_entry),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hw/rtl/tfs_checker.sv
// Port-level checks for the telemetry frame stuffer, bound to the top level.
// Depends on tfs_pkg and telemetry_frame_stuffer_assert.svh.
`timescale 1ns / 1ps
`include "telemetry_frame_stuffer_assert.svh"

module tfs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tfs_pkg::beat_t out_data_o
);

  logic       in_beat;
  logic       out_beat;
  logic       out_held;
  logic       out_end;
  logic       is_subst;
  logic       is_delim;
  logic       len_ok;
  logic       esc_pend_q;
  logic [3:0] beats_q;
  logic [7:0] pend_q;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;
  assign out_held = out_valid_o && out_stall_i;
  assign out_end  = out_data_o.frame_end;

  // Byte classes and the frame length rule seen on the output.
  assign is_subst = (out_data_o.out_byte == tfs_pkg::SubstDelim) ||
                    (out_data_o.out_byte == tfs_pkg::SubstEscape);
  assign is_delim = (out_data_o.out_byte == tfs_pkg::FrameDelim);
  assign len_ok   = out_end ? (beats_q >= 4'd7) : (beats_q < 4'd14);

  // Track escape pairs, beats within the frame and frames in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_pend_q <= 1'b0;
      beats_q    <= '0;
      pend_q     <= '0;
    end else begin
      if (out_beat) begin
        esc_pend_q <= (out_data_o.out_byte == tfs_pkg::EscapeByte) && !out_end;
        beats_q    <= out_end ? 4'd0 : beats_q + 4'd1;
      end
      pend_q <= pend_q + {7'd0, in_beat} - {7'd0, out_beat && out_end};
    end
  end

  `TFS_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_data_o), "held beat changed")
  `TFS_ASSERT_NOW(a_esc_pair, out_valid_o && esc_pend_q, !out_end && is_subst, "escape unpaired")
  `TFS_ASSERT_NOW(a_no_delim, out_valid_o && !out_end, !is_delim, "bare delimiter inside a frame")
  `TFS_ASSERT_NOW(a_frame_len, out_valid_o, len_ok, "frame length out of range")
  `TFS_ASSERT_NOW(a_no_orphan, out_valid_o, pend_q != 8'd0, "beat without an accepted record")

endmodule

bind telemetry_frame_stuffer tfs_checker u_checker (.*);

>>> verif/telemetry_frame_stuffer_tb.sv
// Testbench for the telemetry frame stuffer: directed and random records, with the
// expected wire beats predicted in the bench and compared beat by beat.
// Depends on tfs_pkg and telemetry_frame_stuffer.
`timescale 1ns / 1ps

module telemetry_frame_stuffer_tb;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  tfs_pkg::rec_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  tfs_pkg::beat_t out_data_o;

  // Beats still owed by the block, oldest first.
  tfs_pkg::beat_t expected_beats[$];
  int    error_count = 0;
  // Set for the last part of the run, where neither side idles.
  bit    steady = 1'b0;

  telemetry_frame_stuffer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Free-running clock, 4 ns period.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard limit on the run time, several times the slowest correct run.
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Works out the wire beats of one record: stuffed payload, then the checksum.
  task automatic stuff_frame(input tfs_pkg::rec_t rec);
    logic [tfs_pkg::PayloadBytes-1:0][7:0] payload;
    logic [8:0]                            acc;
    logic [7:0]                            sum;
    payload = {rec.payload_value, rec.sensor_data_id, rec.frame_header};
    sum = 8'h00;
    for (int i = 0; i < tfs_pkg::PayloadBytes; i++) begin
      if (payload[i] == tfs_pkg::FrameDelim) begin
        expected_beats.push_back({tfs_pkg::EscapeByte, 1'b0});
        expected_beats.push_back({tfs_pkg::SubstDelim, 1'b0});
      end else if (payload[i] == tfs_pkg::EscapeByte) begin
        expected_beats.push_back({tfs_pkg::EscapeByte, 1'b0});
        expected_beats.push_back({tfs_pkg::SubstEscape, 1'b0});
      end else begin
        expected_beats.push_back({payload[i], 1'b0});
      end
      // End-around carry: the carry out of bit 7 is added back in.
      acc = {1'b0, sum} + {1'b0, payload[i]};
      acc = {1'b0, acc[7:0]} + {8'h00, acc[8]};
      sum = acc[7:0];
    end
    // The checksum goes out as it is, even when it looks like a framing byte.
    expected_beats.push_back({tfs_pkg::ByteMask - sum, 1'b1});
  endtask

  // Builds a record from its seven payload bytes in wire order.
  function automatic tfs_pkg::rec_t from_bytes(input logic [tfs_pkg::PayloadBytes-1:0][7:0] b);
    tfs_pkg::rec_t rec;
    rec.frame_header   = b[0];
    rec.sensor_data_id = {b[2], b[1]};
    rec.payload_value  = {b[6], b[5], b[4], b[3]};
    return rec;
  endfunction

  // A byte biased toward the framing bytes and the extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return tfs_pkg::FrameDelim;
      1: return tfs_pkg::EscapeByte;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Sends one record; entered and left at a falling edge. Valid stays high when
  // no gap follows, so back-to-back records keep it up.
  task automatic send_record(input tfs_pkg::rec_t rec);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= rec;
    do @(posedge clk_i); while (in_stall_o);
    stuff_frame(rec);
    @(negedge clk_i);
    gap = 0;
    if (!steady && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Lowers valid after the last record of a test; called and
  // left at a falling edge.
  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // All-zero and all-ones records, and one with all-ones fields around an all-zero id.
  task automatic test_field_extremes();
    send_record(from_bytes({tfs_pkg::PayloadBytes{8'h00}}));
    send_record(from_bytes({tfs_pkg::PayloadBytes{8'hFF}}));
    send_record('{frame_header: 8'hFF, sensor_data_id: 16'h0000, payload_value: 32'hFFFF_FFFF});
    stop_sending();
  endtask

  // Framing bytes in the payload, including the longest frame.
  task automatic test_escape_bytes();
    logic [tfs_pkg::PayloadBytes-1:0][7:0] b;
    send_record(from_bytes({tfs_pkg::PayloadBytes{tfs_pkg::FrameDelim}}));
    send_record(from_bytes({tfs_pkg::PayloadBytes{tfs_pkg::EscapeByte}}));
    for (int i = 0; i < tfs_pkg::PayloadBytes; i++) begin
      b[i] = (i % 2 == 0) ? tfs_pkg::FrameDelim : tfs_pkg::EscapeByte;
    end
    send_record(from_bytes(b));
    for (int i = 0; i < tfs_pkg::PayloadBytes; i++) begin
      b[i] = (i % 2 == 0) ? tfs_pkg::EscapeByte : tfs_pkg::FrameDelim;
    end
    send_record(from_bytes(b));
    // One framing byte at each position in turn.
    for (int pos = 0; pos < tfs_pkg::PayloadBytes; pos++) begin
      b = {tfs_pkg::PayloadBytes{8'h11}};
      b[pos] = (pos % 2 == 0) ? tfs_pkg::FrameDelim : tfs_pkg::EscapeByte;
      send_record(from_bytes(b));
    end
    stop_sending();
  endtask

  // Checksums that equal framing bytes, and the end-around carry.
  task automatic test_checksum_cases();
    // Sum 0x81 gives a checksum equal to the frame delimiter.
    send_record(from_bytes({48'h0, 8'h81}));
    // Sum 0x82 gives a checksum equal to the escape byte.
    send_record(from_bytes({48'h0, 8'h82}));
    // 0xFF plus 0x01 wraps to 0x01 through the end-around carry.
    send_record(from_bytes({40'h0, 8'h01, 8'hFF}));
    // Sum 0xFF gives a zero checksum.
    send_record(from_bytes({40'h0, 8'h0F, 8'hF0}));
    stop_sending();
  endtask

  // Random records: some fully random, most built from biased bytes.
  task automatic test_random_traffic(input int count);
    logic [tfs_pkg::PayloadBytes-1:0][7:0] b;
    tfs_pkg::rec_t rec;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 2) == 0) begin
        rec.frame_header   = 8'($urandom);
        rec.sensor_data_id = 16'($urandom);
        rec.payload_value  = $urandom;
      end else begin
        for (int i = 0; i < tfs_pkg::PayloadBytes; i++) b[i] = pick_byte();
        rec = from_bytes(b);
      end
      send_record(rec);
    end
    stop_sending();
  endtask

  // Output-side stalls in random bursts; none once the run is steady.
  initial begin : out_stall_gen
    int burst;
    out_stall_i = 1'b0;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (steady) begin
        out_stall_i <= 1'b0;
        burst = 0;
      end else if (burst > 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 7) == 0) burst = $urandom_range(1, 17);
      end
    end
  end

  // Compares each accepted beat with the oldest expectation.
  always @(posedge clk_i) begin : beat_checker
    tfs_pkg::beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("beat with nothing expected", int'(out_data_o), 0);
      end else begin
        want = expected_beats.pop_front();
        if (out_data_o.out_byte !== want.out_byte)
          report_mismatch("out_byte", int'(out_data_o.out_byte), int'(want.out_byte));
        if (out_data_o.frame_end !== want.frame_end)
          report_mismatch("frame_end", int'(out_data_o.frame_end), int'(want.frame_end));
      end
    end
  end

  // Test sequence.
  initial begin
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_field_extremes();
    test_escape_bytes();
    test_checksum_cases();
    test_random_traffic(360);
    steady = 1'b1;
    test_random_traffic(54);

    // Drain, then give stray beats a chance to show up.
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tfs_pkg.sv
hw/rtl/tfs_front.sv
hw/rtl/tfs_queue.sv
hw/rtl/tfs_back.sv
hw/rtl/telemetry_frame_stuffer.sv
hw/rtl/tfs_checker.sv
verif/telemetry_frame_stuffer_tb.sv
